### rtl/rm2e_pkg.sv
// Shared types, widths and constants of the rotation matrix to Euler angle converter.
`default_nettype none

package rm2e_pkg;

  // CORDIC iterations per arctangent and the length of the arctangent table
  localparam int CORDIC_STAGES = 14;
  localparam int TABLE_LEN     = 24;
  localparam int NUM_STAGES    = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
  // pre-rotation register, iteration cells, rounding register
  localparam int CORDIC_LAT    = NUM_STAGES + 2;

  localparam int IN_W     = 16;  // Q1.14 matrix entry
  localparam int ANG_W    = 16;  // Q2.13 angle
  localparam int THR_W    = 11;  // threshold register
  localparam int OP_W     = 17;  // atan2 operand, holds -(-32768) and sy
  localparam int SCALE_SH = 8;   // operands scaled by 2^8
  localparam int CX_W     = 27;  // CORDIC x/y datapath
  localparam int CZ_W     = 21;  // angle accumulator, units of 2^-16 rad
  localparam int POST_SH  = 3;   // 2^-16 rad to Q2.13
  localparam int SQ_W     = 32;  // sum of squares
  localparam int ROOT_W   = 17;
  localparam int TRIAL_W  = 34;
  localparam int SQRT_STEPS = 17; // root bits 16 down to 0
  localparam int BIT_W    = 5;
  localparam int TAB_W    = 5;

  localparam logic [THR_W-1:0]       THR_RESET   = 11'd1;
  localparam logic signed [CZ_W-1:0] PI_Q16      = 21'sd205887;
  localparam logic signed [CZ_W-1:0] ANGLE_LIMIT = 21'sd25736;
  localparam logic signed [CZ_W-1:0] ROUND_BIAS  = 21'sd4;
  localparam logic signed [ANG_W-1:0] ANG_LIMIT  = ANG_W'(ANGLE_LIMIT);

  typedef struct packed {
    logic signed [IN_W-1:0] m00;
    logic signed [IN_W-1:0] m10;
    logic signed [IN_W-1:0] m20;
    logic signed [IN_W-1:0] m21;
    logic signed [IN_W-1:0] m22;
    logic signed [IN_W-1:0] m11;
    logic signed [IN_W-1:0] m12;
  } mat_t;

  typedef struct packed {
    logic              valid;
    logic [SQ_W-1:0]   rem;
    logic [ROOT_W-1:0] root;
    mat_t              m;
  } sqrt_word_t;

  typedef struct packed {
    logic signed [CX_W-1:0] x;
    logic signed [CX_W-1:0] y;
    logic signed [CZ_W-1:0] z;
    logic                   zero;
  } cordic_word_t;

  typedef struct packed {
    logic valid;
    logic singular;
  } tag_t;

  typedef struct packed {
    logic signed [ANG_W-1:0] angle_x;
    logic signed [ANG_W-1:0] angle_y;
    logic signed [ANG_W-1:0] angle_z;
    logic                    is_singular;
  } out_t;

  // round(atan(2^-i) * 2^16)
  function automatic logic signed [CZ_W-1:0] atan_q16(input logic [TAB_W-1:0] i);
    logic signed [CZ_W-1:0] r;
    case (i)
      5'd0:    r = 21'sd51472;
      5'd1:    r = 21'sd30386;
      5'd2:    r = 21'sd16055;
      5'd3:    r = 21'sd8150;
      5'd4:    r = 21'sd4091;
      5'd5:    r = 21'sd2047;
      5'd6:    r = 21'sd1024;
      5'd7:    r = 21'sd512;
      5'd8:    r = 21'sd256;
      5'd9:    r = 21'sd128;
      5'd10:   r = 21'sd64;
      5'd11:   r = 21'sd32;
      5'd12:   r = 21'sd16;
      5'd13:   r = 21'sd8;
      5'd14:   r = 21'sd4;
      5'd15:   r = 21'sd2;
      5'd16:   r = 21'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/rm2e_if.sv
// Valid/ready channel interfaces: matrix in, angles out, threshold write.
`default_nettype none

interface rm2e_mat_if;
  import rm2e_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] m00;
  logic signed [IN_W-1:0] m10;
  logic signed [IN_W-1:0] m20;
  logic signed [IN_W-1:0] m21;
  logic signed [IN_W-1:0] m22;
  logic signed [IN_W-1:0] m11;
  logic signed [IN_W-1:0] m12;
  modport source (output valid, m00, m10, m20, m21, m22, m11, m12, input ready);
  modport sink   (input valid, m00, m10, m20, m21, m22, m11, m12, output ready);
endinterface

interface rm2e_ang_if;
  import rm2e_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [ANG_W-1:0] angle_x;
  logic signed [ANG_W-1:0] angle_y;
  logic signed [ANG_W-1:0] angle_z;
  logic                    is_singular;
  modport source (output valid, angle_x, angle_y, angle_z, is_singular, input ready);
  modport sink   (input valid, angle_x, angle_y, angle_z, is_singular, output ready);
endinterface

interface rm2e_cfg_if;
  import rm2e_pkg::*;
  logic             valid;
  logic             ready;
  logic [THR_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

### rtl/rotation_matrix_to_euler.sv
// Top level: rotation matrix to x-y-z Euler angles, fully pipelined.
// Takes one matrix word per clock while ready is high and returns one angle word per matrix, in order.
// The path is a chain of register cells that all step together: one stage squares
// m00 and m10, one adds them, 17 square-root cells settle sy one bit each, one stage
// checks sy against the threshold register and picks the atan2 operands, then three
// parallel CORDIC chains of CORDIC_STAGES + 2 cells each finish the angles.
// Throughput is one word per cycle while the output is not stalled. A single-entry
// skid register at the output catches a word the sink does not take; while it holds
// that word the whole chain freezes and the input drops ready, starting the cycle
// after the first stall.
// The threshold write port is always ready; write it only while the block holds no
// matrix in flight.
`default_nettype none

module rotation_matrix_to_euler (
  input logic          clk,
  input logic          rst,
  rm2e_cfg_if.sink     cfg,
  rm2e_mat_if.sink     mat,
  rm2e_ang_if.source   ang
);
  import rm2e_pkg::*;

  // threshold register
  logic [THR_W-1:0] threshold;

  // squaring stage
  logic signed [SQ_W-1:0] sq00;
  logic signed [SQ_W-1:0] sq10;
  logic                   mul_valid;
  logic [SQ_W-1:0]        p00;
  logic [SQ_W-1:0]        p10;
  mat_t                   mul_m;
  mat_t                   mat_in;

  // square-root chain, entry 0 holds the sum
  sqrt_word_t sq [0:SQRT_STEPS];

  // operand stage
  tag_t                   op_tag;
  logic                   singular;
  logic signed [OP_W-1:0] ax_y;
  logic signed [OP_W-1:0] ax_x;
  logic signed [OP_W-1:0] ay_y;
  logic signed [OP_W-1:0] ay_x;
  logic signed [OP_W-1:0] az_y;
  logic signed [OP_W-1:0] az_x;

  // CORDIC outputs and side tags running alongside
  logic signed [ANG_W-1:0] cx;
  logic signed [ANG_W-1:0] cy;
  logic signed [ANG_W-1:0] cz;
  tag_t                    tags [0:CORDIC_LAT-1];

  // output
  logic adv;
  logic skid_full;
  out_t skid_word;
  out_t pipe_word;
  logic pipe_valid;
  out_t out_word;

  // ---- configuration ----
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THR_RESET;
    end else if (cfg.valid) begin
      threshold <= cfg.data;
    end
  end

  // whole chain steps unless the skid register already holds a stalled word
  assign adv       = !skid_full;
  assign mat.ready = adv;

  // ---- squares ----
  assign mat_in = '{m00: mat.m00, m10: mat.m10, m20: mat.m20, m21: mat.m21,
                    m22: mat.m22, m11: mat.m11, m12: mat.m12};
  assign sq00 = mat.m00 * mat.m00;
  assign sq10 = mat.m10 * mat.m10;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
    end else if (adv) begin
      mul_valid <= mat.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p00   <= $unsigned(sq00);
      p10   <= $unsigned(sq10);
      mul_m <= mat_in;
    end
  end

  // ---- sum of squares (at most 2^31, fits) ----
  always_ff @(posedge clk) begin
    if (rst) begin
      sq[0].valid <= 1'b0;
    end else if (adv) begin
      sq[0].valid <= mul_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq[0].rem  <= p00 + p10;
      sq[0].root <= '0;
      sq[0].m    <= mul_m;
    end
  end

  // ---- sy = floor(sqrt(sum)), one bit per cell, MSB first ----
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    rm2e_sqrt_cell u_sqrt (
      .clk    (clk),
      .rst    (rst),
      .en     (adv),
      .bitpos (BIT_W'(SQRT_STEPS - 1 - k)),
      .din    (sq[k]),
      .dout   (sq[k+1])
    );
  end

  // ---- singular test and operand select ----
  // threshold zero never trips since sy is unsigned
  assign singular = sq[SQRT_STEPS].root < ROOT_W'(threshold);

  always_ff @(posedge clk) begin
    if (rst) begin
      op_tag.valid <= 1'b0;
    end else if (adv) begin
      op_tag.valid <= sq[SQRT_STEPS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op_tag.singular <= singular;
      ay_y <= -OP_W'(sq[SQRT_STEPS].m.m20);
      ay_x <= $signed(sq[SQRT_STEPS].root);
      az_y <= OP_W'(sq[SQRT_STEPS].m.m10);
      az_x <= OP_W'(sq[SQRT_STEPS].m.m00);
      if (singular) begin
        // gimbal lock: x angle from the second row
        ax_y <= -OP_W'(sq[SQRT_STEPS].m.m12);
        ax_x <= OP_W'(sq[SQRT_STEPS].m.m11);
      end else begin
        ax_y <= OP_W'(sq[SQRT_STEPS].m.m21);
        ax_x <= OP_W'(sq[SQRT_STEPS].m.m22);
      end
    end
  end

  // ---- three atan2 chains in lockstep ----
  rm2e_cordic u_atan_x (.clk(clk), .en(adv), .y_in(ax_y), .x_in(ax_x), .angle(cx));
  rm2e_cordic u_atan_y (.clk(clk), .en(adv), .y_in(ay_y), .x_in(ay_x), .angle(cy));
  rm2e_cordic u_atan_z (.clk(clk), .en(adv), .y_in(az_y), .x_in(az_x), .angle(cz));

  // tags ride along; only the valid bits are cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CORDIC_LAT; i++) begin
        tags[i].valid <= 1'b0;
      end
    end else if (adv) begin
      tags[0] <= op_tag;
      for (int i = 1; i < CORDIC_LAT; i++) begin
        tags[i] <= tags[i-1];
      end
    end
  end

  // ---- output word, z forced to zero in gimbal lock ----
  assign pipe_valid = tags[CORDIC_LAT-1].valid;

  always_comb begin
    pipe_word.angle_x     = cx;
    pipe_word.angle_y     = cy;
    pipe_word.angle_z     = tags[CORDIC_LAT-1].singular ? '0 : cz;
    pipe_word.is_singular = tags[CORDIC_LAT-1].singular;
  end

  // skid: catch the chain's last word when the sink stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (ang.ready) begin
        skid_full <= 1'b0;
      end
    end else if (pipe_valid && !ang.ready) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_full) begin
      skid_word <= pipe_word;
    end
  end

  assign out_word        = skid_full ? skid_word : pipe_word;
  assign ang.valid       = skid_full || pipe_valid;
  assign ang.angle_x     = out_word.angle_x;
  assign ang.angle_y     = out_word.angle_y;
  assign ang.angle_z     = out_word.angle_z;
  assign ang.is_singular = out_word.is_singular;

endmodule

`default_nettype wire

### rtl/rm2e_sqrt_cell.sv
// One restoring square-root cell: decides one root bit and passes the word on.
`default_nettype none

module rm2e_sqrt_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic [rm2e_pkg::BIT_W-1:0]  bitpos,
  input  rm2e_pkg::sqrt_word_t        din,
  output rm2e_pkg::sqrt_word_t        dout
);
  import rm2e_pkg::*;

  logic [TRIAL_W-1:0] rem_ext;
  logic [TRIAL_W-1:0] root_sh;
  logic [TRIAL_W-1:0] bit_sq;
  logic [TRIAL_W-1:0] trial;
  logic [ROOT_W-1:0]  root_bit;

  // (r + 2^b)^2 - r^2 = r * 2^(b+1) + 2^(2b)
  always_comb begin
    root_sh  = TRIAL_W'(din.root) << (bitpos + BIT_W'(1));
    bit_sq   = TRIAL_W'(1) << {bitpos, 1'b0};
    trial    = root_sh + bit_sq;
    rem_ext  = TRIAL_W'(din.rem);
    root_bit = ROOT_W'(1) << bitpos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.m <= din.m;
      if (rem_ext >= trial) begin
        dout.rem  <= SQ_W'(rem_ext - trial);
        dout.root <= din.root | root_bit;
      end else begin
        dout.rem  <= din.rem;
        dout.root <= din.root;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/rm2e_cordic_cell.sv
// One CORDIC vectoring iteration, registered.
`default_nettype none

module rm2e_cordic_cell (
  input  logic                        clk,
  input  logic                        en,
  input  logic [rm2e_pkg::TAB_W-1:0]  idx,
  input  rm2e_pkg::cordic_word_t      din,
  output rm2e_pkg::cordic_word_t      dout
);
  import rm2e_pkg::*;

  logic signed [CX_W-1:0] xs;
  logic signed [CX_W-1:0] ys;
  logic signed [CZ_W-1:0] step;

  always_comb begin
    xs   = din.x >>> idx;
    ys   = din.y >>> idx;
    step = atan_q16(idx);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.zero <= din.zero;
      if (!din.y[CX_W-1]) begin
        dout.x <= din.x + ys;
        dout.y <= din.y - xs;
        dout.z <= din.z + step;
      end else begin
        dout.x <= din.x - ys;
        dout.y <= din.y + xs;
        dout.z <= din.z - step;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/rm2e_cordic.sv
// Pipelined atan2: pre-rotation into the right half plane, iteration cells, rounding.
`default_nettype none

module rm2e_cordic (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [rm2e_pkg::OP_W-1:0]  y_in,
  input  logic signed [rm2e_pkg::OP_W-1:0]  x_in,
  output logic signed [rm2e_pkg::ANG_W-1:0] angle
);
  import rm2e_pkg::*;

  cordic_word_t           chain [0:NUM_STAGES];
  logic signed [CX_W-1:0] xe;
  logic signed [CX_W-1:0] ye;
  logic signed [CZ_W-1:0] zr;

  always_comb begin
    xe = CX_W'(x_in) <<< SCALE_SH;
    ye = CX_W'(y_in) <<< SCALE_SH;
  end

  // left half plane: rotate by pi first
  always_ff @(posedge clk) begin
    if (en) begin
      chain[0].zero <= (x_in == '0) && (y_in == '0);
      if (x_in[OP_W-1]) begin
        chain[0].x <= -xe;
        chain[0].y <= -ye;
        chain[0].z <= y_in[OP_W-1] ? -PI_Q16 : PI_Q16;
      end else begin
        chain[0].x <= xe;
        chain[0].y <= ye;
        chain[0].z <= '0;
      end
    end
  end

  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_cell
    rm2e_cordic_cell u_cell (
      .clk  (clk),
      .en   (en),
      .idx  (TAB_W'(k)),
      .din  (chain[k]),
      .dout (chain[k+1])
    );
  end

  // round half up to Q2.13
  assign zr = (chain[NUM_STAGES].z + ROUND_BIAS) >>> POST_SH;

  always_ff @(posedge clk) begin
    if (en) begin
      if (chain[NUM_STAGES].zero) begin
        angle <= '0;
      end else if (zr > ANGLE_LIMIT) begin
        angle <= ANG_LIMIT;
      end else if (zr < -ANGLE_LIMIT) begin
        angle <= -ANG_LIMIT;
      end else begin
        angle <= ANG_W'(zr);
      end
    end
  end

endmodule

`default_nettype wire

### rtl/rm2e_checker.sv
// Port-level checks for the converter and the bind that attaches them.
`default_nettype none

module rm2e_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              mat_ready,
  input logic                              ang_valid,
  input logic                              ang_ready,
  input logic signed [rm2e_pkg::ANG_W-1:0] angle_x,
  input logic signed [rm2e_pkg::ANG_W-1:0] angle_y,
  input logic signed [rm2e_pkg::ANG_W-1:0] angle_z,
  input logic                              is_singular
);
  import rm2e_pkg::*;

  // no result pending right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !ang_valid)
    else $error("angle word valid after reset");

  // input only backs up while a result waits
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !mat_ready |-> ang_valid)
    else $error("input stalled with no result pending");

  // gimbal lock zeroes z
  a_sing_z: assert property (@(posedge clk) disable iff (rst)
    ang_valid && is_singular |-> angle_z == '0)
    else $error("singular word with nonzero z angle");

  // angles are saturated to +-pi
  a_range: assert property (@(posedge clk) disable iff (rst)
    ang_valid |-> angle_x <= ANG_LIMIT && angle_x >= -ANG_LIMIT &&
                  angle_y <= ANG_LIMIT && angle_y >= -ANG_LIMIT &&
                  angle_z <= ANG_LIMIT && angle_z >= -ANG_LIMIT)
    else $error("angle outside +-pi");

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    ang_valid && !ang_ready |=> ang_valid && $stable(angle_x) && $stable(angle_y) &&
                                $stable(angle_z) && $stable(is_singular))
    else $error("stalled angle word changed");

endmodule

bind rotation_matrix_to_euler rm2e_checker u_rm2e_checker (
  .clk         (clk),
  .rst         (rst),
  .mat_ready   (mat.ready),
  .ang_valid   (ang.valid),
  .ang_ready   (ang.ready),
  .angle_x     (ang.angle_x),
  .angle_y     (ang.angle_y),
  .angle_z     (ang.angle_z),
  .is_singular (ang.is_singular)
);

`default_nettype wire

### verif/rotation_matrix_to_euler_tb.sv
// Self-checking testbench for the rotation matrix to Euler angle converter.
module rotation_matrix_to_euler_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rm2e_pkg::*;

  localparam int  LATENCY          = 20 + CORDIC_LAT;  // matrix word in to angle word out
  localparam int  HOLD_CYCLES      = 150;              // long output hold, fills the pipe
  localparam int  RANDOM_PER_PHASE = 105;
  localparam real PI_R             = 3.14159265358979;

  // Scoreboard: predicts the angle word of every accepted matrix word and
  // checks the angle words in arrival order.
  class angle_scoreboard;
    out_t             expected_q[$];
    logic [THR_W-1:0] threshold;
    longint           arctan_q16[NUM_STAGES];
    int               mismatches;
    int               n_checked;
    int               n_singular;

    function new();
      threshold = THR_RESET;
      // round(atan(2^-i) * 2^16)
      for (int i = 0; i < NUM_STAGES; i++)
        arctan_q16[i] = $rtoi($atan(2.0 ** (-i)) * 65536.0 + 0.5);
    endfunction

    // floor(sqrt(n)), one result bit per step
    function longint floor_root(longint unsigned n);
      longint unsigned r;
      longint unsigned t;
      r = 0;
      for (int b = 16; b >= 0; b--) begin
        t = r | (64'd1 << b);
        if (t * t <= n) r = t;
      end
      return longint'(r);
    endfunction

    // vectoring CORDIC, operands scaled by 2^8, angle in 2^-16 rad, then Q2.13
    function logic signed [ANG_W-1:0] atan2_q13(longint y_in, longint x_in);
      longint x, y, z, xs, ys;
      if (x_in == 0 && y_in == 0) return '0;
      x = x_in * 256;
      y = y_in * 256;
      z = 0;
      if (x < 0) begin
        // left half plane: turn by pi first
        z = (y >= 0) ? longint'(PI_Q16) : -longint'(PI_Q16);
        x = -x;
        y = -y;
      end
      for (int i = 0; i < NUM_STAGES; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + arctan_q16[i];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - arctan_q16[i];
        end
      end
      z = (z + 4) >>> 3;
      if (z > longint'(ANGLE_LIMIT)) z = longint'(ANGLE_LIMIT);
      if (z < -longint'(ANGLE_LIMIT)) z = -longint'(ANGLE_LIMIT);
      return ANG_W'(z);
    endfunction

    function void note_matrix(mat_t m);
      out_t            want;
      longint unsigned sq;
      longint          sy;
      sq = longint'(m.m00) * longint'(m.m00) + longint'(m.m10) * longint'(m.m10);
      sy = floor_root(sq);
      want.is_singular = (sy < longint'(threshold));
      want.angle_y = atan2_q13(-longint'(m.m20), sy);
      if (want.is_singular) begin
        want.angle_x = atan2_q13(-longint'(m.m12), longint'(m.m11));
        want.angle_z = '0;
      end else begin
        want.angle_x = atan2_q13(longint'(m.m21), longint'(m.m22));
        want.angle_z = atan2_q13(longint'(m.m10), longint'(m.m00));
      end
      expected_q.push_back(want);
    endfunction

    function void check_angles(out_t got);
      out_t want;
      if (expected_q.size() == 0) begin
        $error("angle word with no matrix word pending: x %0d y %0d z %0d singular %0b",
               got.angle_x, got.angle_y, got.angle_z, got.is_singular);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      n_checked++;
      if (want.is_singular) n_singular++;
      if (got.angle_x !== want.angle_x) begin
        $error("angle_x: expected %0d, got %0d", want.angle_x, got.angle_x);
        mismatches++;
      end
      if (got.angle_y !== want.angle_y) begin
        $error("angle_y: expected %0d, got %0d", want.angle_y, got.angle_y);
        mismatches++;
      end
      if (got.angle_z !== want.angle_z) begin
        $error("angle_z: expected %0d, got %0d", want.angle_z, got.angle_z);
        mismatches++;
      end
      if (got.is_singular !== want.is_singular) begin
        $error("is_singular: expected %0b, got %0b", want.is_singular, got.is_singular);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  rm2e_cfg_if cfg_ch ();
  rm2e_mat_if mat_ch ();
  rm2e_ang_if ang_ch ();

  rotation_matrix_to_euler u_dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .mat (mat_ch),
    .ang (ang_ch)
  );

  angle_scoreboard sb = new();
  int  n_items;
  bit  hold_request;   // main flow asks the sink side for one long hold

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // --- stimulus helpers -----------------------------------------------------

  function automatic mat_t mk(int a00, int a10, int a20, int a21, int a22, int a11, int a12);
    mat_t m;
    m.m00 = 16'(a00);
    m.m10 = 16'(a10);
    m.m20 = 16'(a20);
    m.m21 = 16'(a21);
    m.m22 = 16'(a22);
    m.m11 = 16'(a11);
    m.m12 = 16'(a12);
    return m;
  endfunction

  // idle cycles: mostly none or a few, now and then a long one
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic signed [IN_W-1:0] pick_entry(int lo, int hi);
    return 16'($urandom_range(0, hi - lo) + lo);
  endfunction

  function automatic logic signed [IN_W-1:0] to_q14(real v);
    int n;
    n = (v >= 0.0) ? $rtoi(v * 16384.0 + 0.5) : -$rtoi(-v * 16384.0 + 0.5);
    return 16'(n);
  endfunction

  function automatic real unit_rand();
    return $urandom_range(0, 1000000) / 1.0e6;
  endfunction

  // Mostly true rotation matrices (some close to gimbal lock), the rest noise.
  function automatic mat_t rand_matrix();
    mat_t m;
    int   kind;
    real  roll, pitch, yaw, cr, sr, cp, sp, cz, sz;
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      roll = (2.0 * unit_rand() - 1.0) * PI_R;
      yaw  = (2.0 * unit_rand() - 1.0) * PI_R;
      if ($urandom_range(0, 4) == 0) begin
        // within ~0.07 rad of +-pi/2: sy lands around the threshold range
        pitch = PI_R / 2.0 - unit_rand() * 0.07;
        if ($urandom_range(0, 1)) pitch = -pitch;
      end else begin
        pitch = (unit_rand() - 0.5) * PI_R;
      end
      cr = $cos(roll);  sr = $sin(roll);
      cp = $cos(pitch); sp = $sin(pitch);
      cz = $cos(yaw);   sz = $sin(yaw);
      m.m00 = to_q14(cp * cz);
      m.m10 = to_q14(cp * sz);
      m.m20 = to_q14(-sp);
      m.m21 = to_q14(cp * sr);
      m.m22 = to_q14(cp * cr);
      m.m11 = to_q14(sr * sp * sz + cr * cz);
      m.m12 = to_q14(cr * sp * sz - sr * cz);
    end else if (kind < 75) begin
      // any 16-bit pattern, out of range included
      m = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else begin
      m.m00 = pick_entry(-16384, 16384);
      m.m10 = pick_entry(-16384, 16384);
      m.m20 = pick_entry(-16384, 16384);
      m.m21 = pick_entry(-16384, 16384);
      m.m22 = pick_entry(-16384, 16384);
      m.m11 = pick_entry(-16384, 16384);
      m.m12 = pick_entry(-16384, 16384);
      if (kind < 90) begin
        // short first column: singular or close to it
        m.m00 = pick_entry(-2100, 2100);
        m.m10 = pick_entry(-2100, 2100);
      end
    end
    return m;
  endfunction

  // --- channel drivers ------------------------------------------------------

  // Offer one matrix word after 'gap' idle cycles; returns once it is taken.
  // valid stays high on return so back-to-back words need no extra NBA.
  task automatic offer_matrix(input mat_t m, input int gap);
    if (gap > 0) begin
      mat_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    mat_ch.valid <= 1'b1;
    mat_ch.m00   <= m.m00;
    mat_ch.m10   <= m.m10;
    mat_ch.m20   <= m.m20;
    mat_ch.m21   <= m.m21;
    mat_ch.m22   <= m.m22;
    mat_ch.m11   <= m.m11;
    mat_ch.m12   <= m.m12;
    do @(posedge clk); while (mat_ch.ready !== 1'b1);
    sb.note_matrix(m);
    n_items++;
  endtask

  // Stop sending and wait until every expected angle word is back.
  task automatic drain();
    mat_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  // Threshold write; only called with nothing in flight.
  task automatic write_threshold(input logic [THR_W-1:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    sb.threshold = v;
  endtask

  // One sink cycle: present ready, and at the edge check a word if one moved.
  task automatic take_cycle(input logic rdy);
    out_t got;
    ang_ch.ready <= rdy;
    @(posedge clk);
    if (ang_ch.valid === 1'b1 && rdy) begin
      got.angle_x     = ang_ch.angle_x;
      got.angle_y     = ang_ch.angle_y;
      got.angle_z     = ang_ch.angle_z;
      got.is_singular = ang_ch.is_singular;
      sb.check_angles(got);
    end
  endtask

  // --- phases ---------------------------------------------------------------

  // Extremes, pi wrap, zero vectors and both gimbal-lock poles, at the reset
  // threshold of 1.
  task automatic run_directed();
    mat_t dir_q[$];
    dir_q.push_back(mk(16384, 0, 0, 0, 16384, 16384, 0));           // identity
    dir_q.push_back(mk(0, 0, 0, 0, 0, 0, 0));                       // all zero vectors
    dir_q.push_back(mk(16384, 16384, 16384, 16384, 16384, 16384, 16384));
    dir_q.push_back(mk(-16384, -16384, -16384, -16384, -16384, -16384, -16384));
    dir_q.push_back(mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768));
    dir_q.push_back(mk(16384, 0, 0, 0, -16384, -16384, 0));         // x turn by +pi, saturates
    dir_q.push_back(mk(16384, 0, 0, -1, -16384, 16384, 0));         // x just below -pi
    dir_q.push_back(mk(-16384, 0, 0, 0, 16384, -16384, 0));         // z turn by +pi
    dir_q.push_back(mk(-16384, -1, 0, 0, 16384, -16384, 0));        // z just below -pi
    dir_q.push_back(mk(0, 0, -16384, 0, 0, 11585, -11585));         // pitch +pi/2
    dir_q.push_back(mk(0, 0, 16384, 0, 0, 11585, 11585));           // pitch -pi/2
    dir_q.push_back(mk(0, 1, 0, 16384, 0, 0, 16384));               // sy = 1, just regular
    dir_q.push_back(mk(21845, -21846, 21845, -21846, 21845, -21846, 21845));
    dir_q.push_back(mk(-21846, 21845, -21846, 21845, -21846, 21845, -21846));
    dir_q.push_back(mk(-32768, 32767, -32768, 32767, -32768, 32767, -32768));
    dir_q.push_back(mk(0, 16384, 0, 16384, 0, 0, 0));               // z +pi/2, zero x operand
    foreach (dir_q[i]) offer_matrix(dir_q[i], idle_length());
  endtask

  // Write a threshold, hit sy right at it, then a batch of random words.
  task automatic run_phase(input logic [THR_W-1:0] thr);
    bit flat_out;
    write_threshold(thr);
    if (thr == 0) begin
      offer_matrix(mk(0, 0, 0, 0, 0, 0, 0), 0);                    // never singular
    end else begin
      offer_matrix(mk(thr - 1, 0, -300, 5000, -7000, 9000, -2000), 0);
      offer_matrix(mk(thr, 0, -300, 5000, -7000, 9000, -2000), 0);
    end
    for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
      // every 16 words: maybe a stretch with no source gaps at all
      if (i % 16 == 0) flat_out = ($urandom_range(0, 3) == 0);
      offer_matrix(rand_matrix(), flat_out ? 0 : idle_length());
    end
    drain();
  endtask

  // --- sink side: random ready, one long hold on request ----------------------
  initial begin : sink_side
    int gap;
    int run;
    ang_ch.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        repeat (HOLD_CYCLES) take_cycle(1'b0);
      end
      gap = idle_length();
      repeat (gap) take_cycle(1'b0);
      run = $urandom_range(1, 40);
      repeat (run) take_cycle(1'b1);
    end
  end

  // --- main flow ------------------------------------------------------------
  initial begin : main_flow
    rst          <= 1'b1;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data  <= '0;
    mat_ch.valid <= 1'b0;
    mat_ch.m00   <= '0;
    mat_ch.m10   <= '0;
    mat_ch.m20   <= '0;
    mat_ch.m21   <= '0;
    mat_ch.m22   <= '0;
    mat_ch.m11   <= '0;
    mat_ch.m12   <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    run_directed();
    drain();

    // first random phase: sink stalls long enough to back the pipe up to the input
    hold_request = 1'b1;
    run_phase(11'd0);
    run_phase(11'd1024);
    run_phase(11'd2047);
    run_phase(11'd512);
    run_phase(11'd1);

    // a stray word would show up within one pipe latency
    repeat (LATENCY + 8) @(posedge clk);

    $display("covered %0d matrix words, %0d angle words checked, %0d singular",
             n_items, sb.n_checked, sb.n_singular);
    $display("thresholds 1, 0, 1024, 2047, 512, 1 with a %0d-cycle output hold",
             HOLD_CYCLES);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog: several times the slowest legal run
  initial begin : watchdog
    #10_000_000;
    $display("timeout: %0d angle words still pending", sb.expected_q.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
